// ===== rtl/tct_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tct_pkg
// Shared widths, limits, register map codes and the configuration struct of
// the thresholded centroid tracker.
// ---------------------------------------------------------------------------
package tct_pkg;

  // Field and state widths
  localparam int COORD_BITS = 10;
  localparam int RED_W      = 8;
  localparam int SUM_W      = 24;
  localparam int HIT_W      = 14;
  localparam int OFF_W      = COORD_BITS + 1;
  localparam int MAX_POINTS = 8192;

  // Step counter of the shared divider
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_HITS  = 2'd1;
  localparam logic [1:0] REG_CENTER_X  = 2'd2;
  localparam logic [1:0] REG_CENTER_Y  = 2'd3;

  // Reset values of the registers
  localparam logic [RED_W-1:0]      THRESHOLD_RST = RED_W'(50);
  localparam logic [HIT_W-1:0]      MIN_HITS_RST  = HIT_W'(2);
  localparam logic [COORD_BITS-1:0] CENTER_X_RST  = COORD_BITS'(175);
  localparam logic [COORD_BITS-1:0] CENTER_Y_RST  = COORD_BITS'(100);

  typedef struct packed {
    logic [RED_W-1:0]      bright_threshold;
    logic [HIT_W-1:0]      min_hits;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/tct_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tct_regs
// Configuration register file behind a simple APB-style port.
// ---------------------------------------------------------------------------
module tct_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tct_pkg::ADDR_W-1:0]  paddr,
  input  logic [tct_pkg::DATA_W-1:0]  pwdata,
  output logic [tct_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tct_pkg::cfg_t               cfg
);
  import tct_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  // Update the addressed register on the access cycle of a write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bright_threshold <= THRESHOLD_RST;
      cfg_r.min_hits         <= MIN_HITS_RST;
      cfg_r.center_x         <= CENTER_X_RST;
      cfg_r.center_y         <= CENTER_Y_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_THRESHOLD: cfg_r.bright_threshold <= pwdata[RED_W-1:0];
        REG_MIN_HITS:  cfg_r.min_hits         <= pwdata[HIT_W-1:0];
        REG_CENTER_X:  cfg_r.center_x         <= pwdata[COORD_BITS-1:0];
        REG_CENTER_Y:  cfg_r.center_y         <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg_r.bright_threshold);
      REG_MIN_HITS:  prdata = DATA_W'(cfg_r.min_hits);
      REG_CENTER_X:  prdata = DATA_W'(cfg_r.center_x);
      REG_CENTER_Y:  prdata = DATA_W'(cfg_r.center_y);
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/tct_divider.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tct_divider
// Shared restoring divider: one quotient bit per cycle while busy.
// Divisor must stay stable while busy.
// ---------------------------------------------------------------------------
module tct_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tct_pkg::SUM_W-1:0]  dividend,
  input  logic [tct_pkg::HIT_W-1:0]  divisor,
  output logic [tct_pkg::SUM_W-1:0]  quotient,
  output tct_pkg::div_status_t       status
);
  import tct_pkg::*;

  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [HIT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [HIT_W:0]       trial;
  logic [HIT_W:0]       diff;
  logic                 ge;

  // One restoring step: shift in next dividend bit, try to subtract
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[SUM_W-2:0], ge};
      rem_nxt = ge ? diff[HIT_W-1:0] : trial[HIT_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state; payload registers need no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== rtl/thresholded_centroid_tracker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// thresholded_centroid_tracker
// Accumulates bright-pixel coordinates over a frame and reports the offset
// of their centroid from a configured center.
// ---------------------------------------------------------------------------
// Samples are taken one per cycle while the frame is accumulating. On a
// frame-end sample whose frame has more hits than min_hits, the input stalls
// for two 24-step passes through one shared restoring divider (average x,
// then average y) plus sequencing. A frame end without a result does not
// stall the input. The result sits in an output register, so sampling of
// the next frame goes on while it waits to be taken; a further result waits
// in the sequencer until that register is free.
// ---------------------------------------------------------------------------
module thresholded_centroid_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [tct_pkg::RED_W-1:0]         in_red_value,
  input  logic [tct_pkg::COORD_BITS-1:0]    in_pixel_x,
  input  logic [tct_pkg::COORD_BITS-1:0]    in_pixel_y,
  input  logic                              in_frame_end,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tct_pkg::OFF_W-1:0]  out_offset_x,
  output logic signed [tct_pkg::OFF_W-1:0]  out_offset_y,
  output logic [tct_pkg::HIT_W-1:0]         out_hit_count,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tct_pkg::ADDR_W-1:0]        paddr,
  input  logic [tct_pkg::DATA_W-1:0]        pwdata,
  output logic [tct_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);
  import tct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_WRITE
  } state_t;

  cfg_t             cfg;
  div_status_t      div_st;
  logic [SUM_W-1:0] div_q;
  logic [SUM_W-1:0] div_dividend;

  state_t           state_r, state_nxt;
  logic [SUM_W-1:0] sum_x_r, sum_x_nxt;
  logic [SUM_W-1:0] sum_y_r, sum_y_nxt;
  logic [HIT_W-1:0] hits_r, hits_nxt;
  logic             start_r, start_nxt;
  logic [OFF_W-1:0] avg_x_r, avg_x_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0] off_x_r, off_x_nxt;
  logic [OFF_W-1:0] off_y_r, off_y_nxt;
  logic [HIT_W-1:0] cnt_out_r, cnt_out_nxt;

  logic             in_xfer;
  logic             hit;
  logic [SUM_W-1:0] acc_x;
  logic [SUM_W-1:0] acc_y;
  logic [HIT_W-1:0] acc_hits;
  logic [OFF_W-1:0] avg_y;

  tct_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign div_dividend = (state_r == ST_DIV_X) ? sum_x_r : sum_y_r;

  tct_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (div_dividend),
    .divisor  (hits_r),
    .quotient (div_q),
    .status   (div_st)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid & ~in_stall;

  // Decide hit and form the running sums including this sample
  assign hit      = (in_red_value > cfg.bright_threshold) &&
                    (hits_r < HIT_W'(MAX_POINTS));
  assign acc_x    = hit ? sum_x_r + SUM_W'(in_pixel_x) : sum_x_r;
  assign acc_y    = hit ? sum_y_r + SUM_W'(in_pixel_y) : sum_y_r;
  assign acc_hits = hit ? hits_r + 1'b1 : hits_r;
  assign avg_y    = div_q[OFF_W-1:0];

  // Sequence accumulation, the two divisions and the result write
  always_comb begin
    state_nxt     = state_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    hits_nxt      = hits_r;
    start_nxt     = 1'b0;
    avg_x_nxt     = avg_x_r;
    out_valid_nxt = out_valid_r;
    off_x_nxt     = off_x_r;
    off_y_nxt     = off_y_r;
    cnt_out_nxt   = cnt_out_r;

    // drop the result once it is taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          sum_x_nxt = acc_x;
          sum_y_nxt = acc_y;
          hits_nxt  = acc_hits;
          if (in_frame_end) begin
            if (acc_hits > cfg.min_hits) begin
              state_nxt = ST_DIV_X;
              start_nxt = 1'b1;
            end else begin
              sum_x_nxt = '0;
              sum_y_nxt = '0;
              hits_nxt  = '0;
            end
          end
        end
      end
      ST_DIV_X: begin
        if (div_st.done) begin
          avg_x_nxt = div_q[OFF_W-1:0];
          state_nxt = ST_DIV_Y;
          start_nxt = 1'b1;
        end
      end
      ST_DIV_Y: begin
        if (div_st.done) begin
          off_x_nxt   = avg_x_r - {1'b0, cfg.center_x};
          off_y_nxt   = {1'b0, cfg.center_y} - avg_y;
          cnt_out_nxt = hits_r;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // hold until the output register is free, then clear the frame
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          sum_x_nxt     = '0;
          sum_y_nxt     = '0;
          hits_nxt      = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      hits_r      <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      hits_r      <= hits_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avg_x_r   <= avg_x_nxt;
    off_x_r   <= off_x_nxt;
    off_y_r   <= off_y_nxt;
    cnt_out_r <= cnt_out_nxt;
  end

  // Present the result register in ST_WRITE's load only
  logic [OFF_W-1:0] res_x_r;
  logic [OFF_W-1:0] res_y_r;
  logic [HIT_W-1:0] res_cnt_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_WRITE && (!out_valid_r || !out_stall)) begin
      res_x_r   <= off_x_r;
      res_y_r   <= off_y_r;
      res_cnt_r <= cnt_out_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_offset_x  = res_x_r;
  assign out_offset_y  = res_y_r;
  assign out_hit_count = res_cnt_r;

endmodule
